// File: hdl/fba_pkg.sv
// Shared types, codes and fixed widths of the file block allocator.
// No dependencies; every other file of the block refers to it by scoped names.

package fba_pkg;

	// default sizes for the top-level parameters
	localparam int DEF_MAX_NODES       = 64;
	localparam int DEF_MAX_BLOCKS      = 1024;
	localparam int DEF_DIRECT_LINKS    = 8;
	localparam int DEF_MAX_BLOCK_BYTES = 256;

	// fixed widths of the item fields
	localparam int OP_W     = 3;
	localparam int NODE_W   = 6;
	localparam int ATTR_W   = 16;
	localparam int SIZE_W   = 12;
	localparam int BYTE_W   = 8;
	localparam int STAT_W   = 3;
	localparam int TDATA_W  = 48;
	localparam int CFG_IX_W = 2;
	localparam int CFG_D_W  = 11;

	// divider: dividend holds a size plus one
	localparam int DIV_W  = SIZE_W + 1;
	localparam int DIV_CW = 4;

	// bitmap word
	localparam int BMW = 32;
	localparam int BMB = 5;

	localparam logic [OP_W-1:0] OP_RESERVE = 3'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
	localparam logic [OP_W-1:0] OP_SET     = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE   = 3'd3;
	localparam logic [OP_W-1:0] OP_READ    = 3'd4;
	localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_NODE = 3'd1;
	localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
	localparam logic [STAT_W-1:0] ST_NO_BLOCK = 3'd3;
	localparam logic [STAT_W-1:0] ST_NO_NODE  = 3'd4;

	localparam logic [CFG_IX_W-1:0] CFG_BLOCK_SIZE  = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_BLOCK_COUNT = 2'd1;
	localparam logic [CFG_IX_W-1:0] CFG_NODE_COUNT  = 2'd2;

	typedef struct packed {
		logic grab;
		logic free;
	} bm_cmd_t;

	typedef struct packed {
		logic ready;
		logic done;
		logic ok;
	} bm_rsp_t;

endpackage

// File: hdl/file_block_allocator_top.sv
// File node allocator: node table, direct link table and sequencer on top of
// fba_bitmap, fba_data and fba_div. Depends on fba_pkg.
//
//  port group      dir  role
//  s_t*            in   operation item (op, node_index, attrs, position, write_byte)
//  m_t*            out  result item (status, node_out, read_byte, file_size, node_mode)
//  cfg_*           in   register writes: block_size, block_count, node_count
//
// One item at a time. Query reads the node entry; reserve scans the nodes (one node
// a cycle) and then writes DIRECT_LINKS empty links; release visits every link.
// Set size and growing writes run the divider and then walk the links, scanning
// bitmap words for each block reserved; byte reads and writes add a second divide
// and a data store access. After reset the data store (MAX_BLOCKS * MAX_BLOCK_BYTES
// entries) is swept to zero before s_tready rises.
// A result waits in the output register while the next item is accepted.

module file_block_allocator_top #(
	parameter int MAX_NODES       = fba_pkg::DEF_MAX_NODES,
	parameter int MAX_BLOCKS      = fba_pkg::DEF_MAX_BLOCKS,
	parameter int DIRECT_LINKS    = fba_pkg::DEF_DIRECT_LINKS,
	parameter int MAX_BLOCK_BYTES = fba_pkg::DEF_MAX_BLOCK_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// op[2:0], node_index[8:3], attrs[24:9], position[36:25], write_byte[44:37]
	input  logic [fba_pkg::TDATA_W-1:0]   s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[2:0], node_out[8:3], read_byte[16:9], file_size[28:17], node_mode[44:29]
	output logic [fba_pkg::TDATA_W-1:0]   m_tdata,
	input  logic                          cfg_we,
	input  logic [fba_pkg::CFG_IX_W-1:0]  cfg_index,
	input  logic [fba_pkg::CFG_D_W-1:0]   cfg_data
);

	localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int NCW   = $clog2(MAX_NODES + 1);
	localparam int BW    = $clog2(MAX_BLOCKS + 1);
	localparam int LW    = (DIRECT_LINKS > 1) ? $clog2(DIRECT_LINKS) : 1;
	localparam int SW    = $clog2(MAX_BLOCK_BYTES + 1);
	localparam int LIMW  = $clog2(MAX_BLOCK_BYTES * DIRECT_LINKS + 1);
	localparam int CW    = (LIMW > fba_pkg::DIV_W) ? LIMW : fba_pkg::DIV_W;
	localparam int DEPTH = MAX_BLOCKS * MAX_BLOCK_BYTES;
	localparam int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LDEP  = MAX_NODES * (1 << LW);
	localparam int NMW   = fba_pkg::ATTR_W + fba_pkg::SIZE_W;

	localparam logic [BW-1:0] NO_BLK = BW'(MAX_BLOCKS);
	localparam logic [LW-1:0] LAST_K = LW'(DIRECT_LINKS - 1);

	typedef enum logic [19:0] {
		S_INIT    = 20'h00001,
		S_IDLE    = 20'h00002,
		S_NSCAN   = 20'h00004,
		S_LINIT   = 20'h00008,
		S_NRD     = 20'h00010,
		S_DISP    = 20'h00020,
		S_RSZ     = 20'h00040,
		S_NEED    = 20'h00080,
		S_LRD     = 20'h00100,
		S_LCHK    = 20'h00200,
		S_GRAB    = 20'h00400,
		S_FREE    = 20'h00800,
		S_REND    = 20'h01000,
		S_POSDIV  = 20'h02000,
		S_POSWAIT = 20'h04000,
		S_PRD     = 20'h08000,
		S_PCHK    = 20'h10000,
		S_DACC    = 20'h20000,
		S_DDAT    = 20'h40000,
		S_OUT     = 20'h80000
	} state_t;

	state_t state_q;

	// configuration
	logic [8:0]  bsz_q;
	logic [10:0] bcnt_q;
	logic [6:0]  ncnt_q;
	logic [SW-1:0]   eff_bs;
	logic [BW-1:0]   eff_blocks;
	logic [NCW-1:0]  eff_nodes;
	logic [LIMW-1:0] lim;

	// item and result
	logic [fba_pkg::OP_W-1:0]   op_q;
	logic [NW-1:0]              nd_q;
	logic [fba_pkg::ATTR_W-1:0] attrs_q;
	logic [fba_pkg::SIZE_W-1:0] pos_q;
	logic [fba_pkg::BYTE_W-1:0] wb_q;
	logic [fba_pkg::STAT_W-1:0] status_q;
	logic [fba_pkg::NODE_W-1:0] nout_q;
	logic [fba_pkg::BYTE_W-1:0] rd_q;
	logic [fba_pkg::SIZE_W-1:0] bytes_q;
	logic [fba_pkg::ATTR_W-1:0] attr_q;
	logic                       m_tvalid_q;
	logic [fba_pkg::TDATA_W-1:0] m_tdata_q;

	// sequencer scratch
	logic [MAX_NODES-1:0]      used_q;
	logic [NCW-1:0]            i_q;
	logic [LW-1:0]             k_q;
	logic [LW-1:0]             qi_q;
	logic [fba_pkg::DIV_W-1:0] need_q;
	logic [fba_pkg::DIV_W-1:0] rsz_q;
	logic [fba_pkg::DIV_W-1:0] to_q;
	logic [SW-1:0]             r_q;
	logic [DW-1:0]             daddr_q;

	// input fields
	logic [fba_pkg::OP_W-1:0]   in_op;
	logic [fba_pkg::NODE_W-1:0] in_nd;
	logic [fba_pkg::ATTR_W-1:0] in_attrs;
	logic [fba_pkg::SIZE_W-1:0] in_pos;
	logic [fba_pkg::BYTE_W-1:0] in_wb;

	// node memory: {attr, bytes}
	logic [NMW-1:0]    node_mem [MAX_NODES];
	logic [NMW-1:0]    node_rdata_q;
	logic              node_we;
	logic [NW-1:0]     node_waddr;
	logic [NMW-1:0]    node_wdata;
	logic [fba_pkg::SIZE_W-1:0] n_bytes;
	logic [fba_pkg::ATTR_W-1:0] n_attr;

	// link memory
	logic [BW-1:0]     link_mem [LDEP];
	logic [BW-1:0]     link_rdata_q;
	logic              link_we;
	logic [BW-1:0]     link_wdata;
	logic [NW+LW-1:0]  link_raddr;
	logic [NW+LW-1:0]  link_waddr;

	// sub-units
	fba_pkg::bm_cmd_t          bm_cmd;
	fba_pkg::bm_rsp_t          bm_rsp;
	logic [BW-1:0]             grab_idx;
	logic                      div_start;
	logic [fba_pkg::DIV_W-1:0] div_dividend;
	logic                      div_done;
	logic [fba_pkg::DIV_W-1:0] div_quot;
	logic [SW-1:0]             div_rem;
	logic                      data_ready;
	logic                      data_we;
	logic [fba_pkg::BYTE_W-1:0] data_rdata;

	logic                      take;
	logic                      k_in_need;
	logic                      wr_range;
	logic [fba_pkg::DIV_W-1:0] to_c;
	logic                      out_free;

	assign in_op    = s_tdata[2:0];
	assign in_nd    = s_tdata[8:3];
	assign in_attrs = s_tdata[24:9];
	assign in_pos   = s_tdata[36:25];
	assign in_wb    = s_tdata[44:37];

	assign s_tready = (state_q == S_IDLE);
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	// effective register values
	always_comb begin
		if (bsz_q == '0) begin
			eff_bs = SW'(1);
		end else if (32'(bsz_q) > 32'(MAX_BLOCK_BYTES)) begin
			eff_bs = SW'(MAX_BLOCK_BYTES);
		end else begin
			eff_bs = SW'(bsz_q);
		end
		eff_blocks = (32'(bcnt_q) > 32'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : BW'(bcnt_q);
		eff_nodes  = (32'(ncnt_q) > 32'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(ncnt_q);
		lim        = LIMW'(eff_bs) * LIMW'(DIRECT_LINKS);
	end

	always_comb begin
		n_bytes   = node_rdata_q[fba_pkg::SIZE_W-1:0];
		n_attr    = node_rdata_q[NMW-1:fba_pkg::SIZE_W];
		k_in_need = 32'(k_q) < 32'(need_q);
		wr_range  = (op_q == fba_pkg::OP_WRITE) && ({1'b0, pos_q} >= to_q);
		if ((CW'(pos_q) + CW'(1)) > CW'(lim)) begin
			to_c = fba_pkg::DIV_W'(lim);
		end else begin
			to_c = {1'b0, pos_q} + 1'b1;
		end
	end

	// memory ports and unit commands
	always_comb begin
		node_we      = 1'b0;
		node_waddr   = nd_q;
		node_wdata   = {attr_q, rsz_q[fba_pkg::SIZE_W-1:0]};
		link_we      = 1'b0;
		link_wdata   = NO_BLK;
		link_waddr   = {nd_q, k_q};
		link_raddr   = {nd_q, k_q};
		bm_cmd       = '0;
		div_start    = 1'b0;
		div_dividend = rsz_q;
		data_we      = 1'b0;
		case (state_q)
			S_NSCAN: begin
				node_waddr = NW'(i_q);
				node_wdata = {attrs_q, fba_pkg::SIZE_W'(0)};
				node_we    = (i_q < eff_nodes) && !used_q[NW'(i_q)];
			end
			S_LINIT: begin
				link_we = 1'b1;
			end
			S_RSZ: begin
				node_we   = 1'b1;
				div_start = 1'b1;
			end
			S_LCHK: begin
				if (k_in_need) begin
					bm_cmd.grab = (link_rdata_q == NO_BLK);
				end else begin
					link_we     = 1'b1;
					bm_cmd.free = (link_rdata_q != NO_BLK);
				end
			end
			S_GRAB: begin
				link_we    = bm_rsp.done && bm_rsp.ok;
				link_wdata = grab_idx;
			end
			S_REND: begin
				node_we    = 1'b1;
				node_wdata = '0;
			end
			S_POSDIV: begin
				div_dividend = {1'b0, pos_q};
				div_start    = !wr_range;
			end
			S_PRD: begin
				link_raddr = {nd_q, qi_q};
			end
			S_DACC: begin
				data_we = (op_q == fba_pkg::OP_WRITE);
			end
			default: begin
				node_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= node_wdata;
		end
		node_rdata_q <= node_mem[nd_q];
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rdata_q <= link_mem[link_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			bsz_q      <= 9'd256;
			bcnt_q     <= 11'd1024;
			ncnt_q     <= 7'd64;
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			op_q       <= '0;
			nd_q       <= '0;
			attrs_q    <= '0;
			pos_q      <= '0;
			wb_q       <= '0;
			status_q   <= '0;
			nout_q     <= '0;
			rd_q       <= '0;
			bytes_q    <= '0;
			attr_q     <= '0;
			i_q        <= '0;
			k_q        <= '0;
			qi_q       <= '0;
			need_q     <= '0;
			rsz_q      <= '0;
			to_q       <= '0;
			r_q        <= '0;
			daddr_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fba_pkg::CFG_BLOCK_SIZE:  bsz_q  <= cfg_data[8:0];
					fba_pkg::CFG_BLOCK_COUNT: bcnt_q <= cfg_data;
					fba_pkg::CFG_NODE_COUNT:  ncnt_q <= cfg_data[6:0];
					default: begin
						bsz_q <= bsz_q;
					end
				endcase
			end

			// in S_OUT the valid flag is handled by the state itself
			if (m_tvalid_q && m_tready && (state_q != S_OUT)) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_INIT: begin
					if (bm_rsp.ready && data_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						op_q     <= in_op;
						nd_q     <= NW'(in_nd);
						attrs_q  <= in_attrs;
						pos_q    <= in_pos;
						wb_q     <= in_wb;
						status_q <= fba_pkg::ST_OK;
						nout_q   <= '0;
						rd_q     <= '0;
						bytes_q  <= '0;
						attr_q   <= '0;
						i_q      <= '0;
						if (in_op == fba_pkg::OP_RESERVE) begin
							state_q <= S_NSCAN;
						end else if (in_op > fba_pkg::OP_QUERY) begin
							status_q <= fba_pkg::ST_RANGE;
							state_q  <= S_OUT;
						end else if ((32'(in_nd) >= 32'(eff_nodes))
								|| !used_q[NW'(in_nd)]) begin
							status_q <= fba_pkg::ST_BAD_NODE;
							nout_q   <= in_nd;
							state_q  <= S_OUT;
						end else begin
							nout_q  <= in_nd;
							state_q <= S_NRD;
						end
					end
				end
				S_NSCAN: begin
					if (i_q < eff_nodes) begin
						if (!used_q[NW'(i_q)]) begin
							used_q[NW'(i_q)] <= 1'b1;
							nd_q    <= NW'(i_q);
							nout_q  <= fba_pkg::NODE_W'(i_q);
							attr_q  <= attrs_q;
							k_q     <= '0;
							state_q <= S_LINIT;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						status_q <= fba_pkg::ST_NO_NODE;
						state_q  <= S_OUT;
					end
				end
				S_LINIT: begin
					if (k_q == LAST_K) begin
						state_q <= S_OUT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_NRD: begin
					state_q <= S_DISP;
				end
				S_DISP: begin
					bytes_q <= n_bytes;
					attr_q  <= n_attr;
					case (op_q)
						fba_pkg::OP_RELEASE: begin
							need_q  <= '0;
							k_q     <= '0;
							state_q <= S_LRD;
						end
						fba_pkg::OP_SET: begin
							if (CW'(pos_q) > CW'(lim)) begin
								status_q <= fba_pkg::ST_RANGE;
								state_q  <= S_OUT;
							end else begin
								rsz_q   <= {1'b0, pos_q};
								state_q <= S_RSZ;
							end
						end
						fba_pkg::OP_WRITE: begin
							if (pos_q > n_bytes) begin
								status_q <= fba_pkg::ST_RANGE;
								state_q  <= S_OUT;
							end else begin
								to_q <= to_c;
								if (to_c > {1'b0, n_bytes}) begin
									rsz_q   <= to_c;
									state_q <= S_RSZ;
								end else begin
									state_q <= S_POSDIV;
								end
							end
						end
						fba_pkg::OP_READ: begin
							if (pos_q >= n_bytes) begin
								status_q <= fba_pkg::ST_RANGE;
								state_q  <= S_OUT;
							end else begin
								state_q <= S_POSDIV;
							end
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_RSZ: begin
					// size is stored before any block is reserved
					bytes_q <= rsz_q[fba_pkg::SIZE_W-1:0];
					state_q <= S_NEED;
				end
				S_NEED: begin
					if (div_done) begin
						need_q  <= div_quot + fba_pkg::DIV_W'(div_rem != '0);
						k_q     <= '0;
						state_q <= S_LRD;
					end
				end
				S_LRD: begin
					state_q <= S_LCHK;
				end
				S_LCHK: begin
					if (k_in_need && (link_rdata_q == NO_BLK)) begin
						state_q <= S_GRAB;
					end else if (!k_in_need && (link_rdata_q != NO_BLK)) begin
						state_q <= S_FREE;
					end else if (k_q != LAST_K) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_LRD;
					end else if (op_q == fba_pkg::OP_RELEASE) begin
						state_q <= S_REND;
					end else if (op_q == fba_pkg::OP_SET) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_POSDIV;
					end
				end
				S_GRAB: begin
					if (bm_rsp.done) begin
						if (!bm_rsp.ok) begin
							// stop the walk; a write goes on with whatever links exist
							if (op_q == fba_pkg::OP_SET) begin
								status_q <= fba_pkg::ST_NO_BLOCK;
								state_q  <= S_OUT;
							end else begin
								state_q <= S_POSDIV;
							end
						end else if (k_q != LAST_K) begin
							k_q     <= k_q + 1'b1;
							state_q <= S_LRD;
						end else if (op_q == fba_pkg::OP_SET) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_POSDIV;
						end
					end
				end
				S_FREE: begin
					if (bm_rsp.done) begin
						if (k_q != LAST_K) begin
							k_q     <= k_q + 1'b1;
							state_q <= S_LRD;
						end else if (op_q == fba_pkg::OP_RELEASE) begin
							state_q <= S_REND;
						end else if (op_q == fba_pkg::OP_SET) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_POSDIV;
						end
					end
				end
				S_REND: begin
					used_q[nd_q] <= 1'b0;
					bytes_q      <= '0;
					attr_q       <= '0;
					state_q      <= S_OUT;
				end
				S_POSDIV: begin
					if (wr_range) begin
						status_q <= fba_pkg::ST_RANGE;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_POSWAIT;
					end
				end
				S_POSWAIT: begin
					if (div_done) begin
						if (32'(div_quot) >= 32'(DIRECT_LINKS)) begin
							status_q <= fba_pkg::ST_RANGE;
							state_q  <= S_OUT;
						end else begin
							qi_q    <= LW'(div_quot);
							r_q     <= div_rem;
							state_q <= S_PRD;
						end
					end
				end
				S_PRD: begin
					state_q <= S_PCHK;
				end
				S_PCHK: begin
					if (link_rdata_q == NO_BLK) begin
						status_q <= fba_pkg::ST_NO_BLOCK;
						state_q  <= S_OUT;
					end else begin
						daddr_q <= DW'(32'(link_rdata_q) * 32'(eff_bs) + 32'(r_q));
						state_q <= S_DACC;
					end
				end
				S_DACC: begin
					if (op_q == fba_pkg::OP_READ) begin
						state_q <= S_DDAT;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DDAT: begin
					rd_q    <= data_rdata;
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {3'b000, attr_q, bytes_q, rd_q, nout_q, status_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	fba_bitmap #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.BW         (BW)
	) u_bitmap (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (bm_cmd),
		.free_idx   (link_rdata_q),
		.eff_blocks (eff_blocks),
		.rsp        (bm_rsp),
		.grab_idx   (grab_idx)
	);

	fba_div #(
		.SW (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (eff_bs),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	fba_data #(
		.DEPTH (DEPTH),
		.DW    (DW)
	) u_data (
		.clk    (clk),
		.arst_n (arst_n),
		.ready  (data_ready),
		.we     (data_we),
		.addr   (daddr_q),
		.wdata  (wb_q),
		.rdata  (data_rdata)
	);

endmodule

// File: hdl/fba_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on fba_pkg for the dividend width.

module fba_div #(
	parameter int SW = 9
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fba_pkg::DIV_W-1:0]  dividend,
	input  logic [SW-1:0]              divisor,
	output logic                       done,
	output logic [fba_pkg::DIV_W-1:0]  quot,
	output logic [SW-1:0]              rem
);

	logic                       busy_q;
	logic [fba_pkg::DIV_CW-1:0] cnt_q;
	logic [fba_pkg::DIV_W-1:0]  quot_q;
	logic [SW-1:0]              rem_q;
	logic [SW:0]                rsh;
	logic [SW:0]                diff;
	logic                       ge;

	always_comb begin
		rsh  = {rem_q, quot_q[fba_pkg::DIV_W-1]};
		ge   = rsh >= {1'b0, divisor};
		diff = rsh - {1'b0, divisor};
	end

	assign done = busy_q && (cnt_q == '0);
	assign quot = quot_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			quot_q <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= fba_pkg::DIV_CW'(fba_pkg::DIV_W);
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_q - 1'b1;
				quot_q <= {quot_q[fba_pkg::DIV_W-2:0], ge};
				rem_q  <= ge ? diff[SW-1:0] : rsh[SW-1:0];
			end
		end
	end

endmodule

// File: hdl/fba_bitmap.sv
// First-free block bitmap held in a word-wide memory, with grab and free commands.
// Depends on fba_pkg for the command and response structs and the word width.

module fba_bitmap #(
	parameter int MAX_BLOCKS = fba_pkg::DEF_MAX_BLOCKS,
	parameter int BW         = $clog2(MAX_BLOCKS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fba_pkg::bm_cmd_t cmd,
	input  logic [BW-1:0]    free_idx,
	input  logic [BW-1:0]    eff_blocks,
	output fba_pkg::bm_rsp_t rsp,
	output logic [BW-1:0]    grab_idx
);

	localparam int NR  = (MAX_BLOCKS + fba_pkg::BMW - 1) / fba_pkg::BMW;
	localparam int RIW = (NR > 1) ? $clog2(NR) : 1;

	typedef enum logic [5:0] {
		B_CLR  = 6'b000001,
		B_IDLE = 6'b000010,
		B_GRD  = 6'b000100,
		B_GCHK = 6'b001000,
		B_FRD  = 6'b010000,
		B_FWR  = 6'b100000
	} bm_state_t;

	bm_state_t                 state_q;
	logic [RIW-1:0]            row_q;
	logic [fba_pkg::BMB-1:0]   fbit_q;
	logic [fba_pkg::BMW-1:0]   mem [NR];
	logic [fba_pkg::BMW-1:0]   rdata_q;
	logic                      we;
	logic [fba_pkg::BMW-1:0]   wdata;
	logic [fba_pkg::BMW-1:0]   avail;
	logic [fba_pkg::BMB-1:0]   first;
	logic                      any;
	logic                      last_row;
	logic [31:0]               fidx;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[row_q] <= wdata;
		end
		rdata_q <= mem[row_q];
	end

	// free bits of the row that lie below the configured block count
	always_comb begin
		avail = '0;
		for (int j = 0; j < fba_pkg::BMW; j++) begin
			avail[j] = !rdata_q[j]
				&& ((32'(row_q) * 32'(fba_pkg::BMW) + 32'(j)) < 32'(eff_blocks));
		end
		first = '0;
		for (int j = fba_pkg::BMW - 1; j >= 0; j--) begin
			if (avail[j]) begin
				first = fba_pkg::BMB'(j);
			end
		end
		any = |avail;
		last_row = (32'(row_q) == 32'(NR - 1))
			|| ((32'(row_q) + 32'd1) * 32'(fba_pkg::BMW) >= 32'(eff_blocks));
		fidx = 32'(free_idx);
	end

	always_comb begin
		we    = 1'b0;
		wdata = '0;
		case (state_q)
			B_CLR: begin
				we = 1'b1;
			end
			B_GCHK: begin
				we    = any;
				wdata = rdata_q | (fba_pkg::BMW'(1) << first);
			end
			B_FWR: begin
				we    = 1'b1;
				wdata = rdata_q & ~(fba_pkg::BMW'(1) << fbit_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign rsp.ready = (state_q != B_CLR);
	assign rsp.done  = ((state_q == B_GCHK) && (any || last_row)) || (state_q == B_FWR);
	assign rsp.ok    = (state_q == B_GCHK) && any;
	assign grab_idx  = BW'(32'(row_q) * 32'(fba_pkg::BMW) + 32'(first));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLR;
			row_q   <= '0;
			fbit_q  <= '0;
		end else begin
			case (state_q)
				B_CLR: begin
					if (32'(row_q) == 32'(NR - 1)) begin
						state_q <= B_IDLE;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				B_IDLE: begin
					if (cmd.grab) begin
						row_q   <= '0;
						state_q <= B_GRD;
					end else if (cmd.free) begin
						row_q   <= RIW'(fidx >> fba_pkg::BMB);
						fbit_q  <= fidx[fba_pkg::BMB-1:0];
						state_q <= B_FRD;
					end
				end
				B_GRD: begin
					state_q <= B_GCHK;
				end
				B_GCHK: begin
					if (any || last_row) begin
						state_q <= B_IDLE;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= B_GRD;
					end
				end
				B_FRD: begin
					state_q <= B_FWR;
				end
				B_FWR: begin
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/fba_data.sv
// Byte store of all data blocks, swept to zero after reset.
// Depends on fba_pkg for the byte width.

module fba_data #(
	parameter int DEPTH = fba_pkg::DEF_MAX_BLOCKS * fba_pkg::DEF_MAX_BLOCK_BYTES,
	parameter int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	output logic                      ready,
	input  logic                      we,
	input  logic [DW-1:0]             addr,
	input  logic [fba_pkg::BYTE_W-1:0] wdata,
	output logic [fba_pkg::BYTE_W-1:0] rdata
);

	logic [fba_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [DW:0]                clr_q;
	logic                       mem_we;
	logic [DW-1:0]              mem_addr;
	logic [fba_pkg::BYTE_W-1:0] mem_wdata;

	assign ready = (32'(clr_q) == 32'(DEPTH));

	always_comb begin
		if (ready) begin
			mem_we    = we;
			mem_addr  = addr;
			mem_wdata = wdata;
		end else begin
			mem_we    = 1'b1;
			mem_addr  = clr_q[DW-1:0];
			mem_wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rdata <= mem[mem_addr];
	end

	// one entry a cycle until the whole store reads zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!ready) begin
			clr_q <= clr_q + 1'b1;
		end
	end

endmodule

// File: dv/tb_file_block_allocator_top.sv
// Self-checking bench for file_block_allocator_top: predicts every result item from its
// own node table, link table, block bitmap and byte store. Depends on fba_pkg.
// Randomized sender bursts and receiver stalls; register writes only between phases.

module tb_file_block_allocator_top;

	localparam int NODES = fba_pkg::DEF_MAX_NODES;
	localparam int BLOCKS = fba_pkg::DEF_MAX_BLOCKS;
	localparam int LINKS = fba_pkg::DEF_DIRECT_LINKS;
	localparam int BYTES = fba_pkg::DEF_MAX_BLOCK_BYTES;
	localparam int NO_BLK = BLOCKS;
	localparam int IDLE_LIMIT = 1000000;
	localparam logic [fba_pkg::OP_W-1:0] OP_UNUSED_A = 3'd6;
	localparam logic [fba_pkg::OP_W-1:0] OP_UNUSED_B = 3'd7;

	// last member sits in the lowest bits
	typedef struct packed {
		logic [fba_pkg::ATTR_W-1:0] mode;
		logic [fba_pkg::SIZE_W-1:0] size;
		logic [fba_pkg::BYTE_W-1:0] rd;
		logic [fba_pkg::NODE_W-1:0] node;
		logic [fba_pkg::STAT_W-1:0] status;
	} fs_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [fba_pkg::TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [fba_pkg::TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [fba_pkg::CFG_IX_W-1:0] cfg_index = fba_pkg::CFG_BLOCK_SIZE;
	logic [fba_pkg::CFG_D_W-1:0] cfg_data = '0;

	file_block_allocator_top u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow of the allocator
	logic [8:0] reg_bsize = 9'd256;
	logic [10:0] reg_bcount = 11'd1024;
	logic [6:0] reg_ncount = 7'd64;
	logic node_used [NODES];
	logic [15:0] node_attr [NODES];
	int node_bytes [NODES];
	int link_tab [NODES*LINKS];
	logic blk_used [BLOCKS];
	logic [7:0] byte_store [BLOCKS*BYTES];

	logic [fba_pkg::TDATA_W-1:0] pending_items [$];
	fs_result_t expected_results [$];
	int fail_count = 0;
	int result_count = 0;

	function automatic int eff_bsize();
		if (reg_bsize == 0) return 1;
		if (reg_bsize > BYTES) return BYTES;
		return reg_bsize;
	endfunction

	function automatic int eff_nodes();
		return (reg_ncount > NODES) ? NODES : reg_ncount;
	endfunction

	function automatic int take_first_free_block();
		int n;
		n = (reg_bcount > BLOCKS) ? BLOCKS : reg_bcount;
		for (int b = 0; b < n; b++)
			if (!blk_used[b]) begin
				blk_used[b] = 1'b1;
				return b;
			end
		return NO_BLK;
	endfunction

	function automatic void drop_link(int nd, int k);
		if (link_tab[nd*LINKS+k] < BLOCKS) blk_used[link_tab[nd*LINKS+k]] = 1'b0;
		link_tab[nd*LINKS+k] = NO_BLK;
	endfunction

	// size is stored before any block is reserved
	function automatic logic [fba_pkg::STAT_W-1:0] resize_node(int nd, int size);
		int bs, need, b;
		bs = eff_bsize();
		if (size > bs * LINKS) return fba_pkg::ST_RANGE;
		node_bytes[nd] = size & 12'hFFF;
		need = (size + bs - 1) / bs;
		for (int k = 0; k < LINKS; k++) begin
			if (k < need) begin
				if (link_tab[nd*LINKS+k] == NO_BLK) begin
					b = take_first_free_block();
					if (b == NO_BLK) return fba_pkg::ST_NO_BLOCK;
					link_tab[nd*LINKS+k] = b;
				end
			end else
				drop_link(nd, k);
		end
		return fba_pkg::ST_OK;
	endfunction

	function automatic fs_result_t apply_op(logic [fba_pkg::OP_W-1:0] op, int nd,
			logic [15:0] attrs, int pos, logic [7:0] wb);
		fs_result_t r;
		int bs, lim, upto, b;
		r = '0;
		bs = eff_bsize();
		lim = bs * LINKS;
		if (op == fba_pkg::OP_RESERVE) begin
			r.status = fba_pkg::ST_NO_NODE;
			for (int i = 0; i < eff_nodes(); i++)
				if (!node_used[i]) begin
					node_used[i] = 1'b1;
					node_attr[i] = attrs;
					for (int k = 0; k < LINKS; k++) link_tab[i*LINKS+k] = NO_BLK;
					r.status = fba_pkg::ST_OK;
					r.node = fba_pkg::NODE_W'(i);
					r.size = fba_pkg::SIZE_W'(node_bytes[i]);
					r.mode = node_attr[i];
					break;
				end
		end else if (op == OP_UNUSED_A || op == OP_UNUSED_B) begin
			r.status = fba_pkg::ST_RANGE;
		end else if (nd >= eff_nodes() || !node_used[nd]) begin
			r.status = fba_pkg::ST_BAD_NODE;
			r.node = fba_pkg::NODE_W'(nd);
		end else begin
			r.node = fba_pkg::NODE_W'(nd);
			r.status = fba_pkg::ST_OK;
			case (op)
				fba_pkg::OP_RELEASE: begin
					for (int k = 0; k < LINKS; k++) drop_link(nd, k);
					node_used[nd] = 1'b0;
					node_attr[nd] = '0;
					node_bytes[nd] = 0;
				end
				fba_pkg::OP_SET: r.status = resize_node(nd, pos);
				fba_pkg::OP_WRITE: begin
					upto = pos + 1;
					if (pos > node_bytes[nd]) r.status = fba_pkg::ST_RANGE;
					else begin
						if (upto > lim) upto = lim;
						if (upto > node_bytes[nd]) void'(resize_node(nd, upto));
						if (pos >= upto) r.status = fba_pkg::ST_RANGE;
						else begin
							b = link_tab[nd*LINKS + pos/bs];
							if (b >= BLOCKS) r.status = fba_pkg::ST_NO_BLOCK;
							else byte_store[b*bs + pos%bs] = wb;
						end
					end
				end
				fba_pkg::OP_READ: begin
					if (pos >= node_bytes[nd] || pos/bs >= LINKS)
						r.status = fba_pkg::ST_RANGE;
					else begin
						b = link_tab[nd*LINKS + pos/bs];
						if (b >= BLOCKS) r.status = fba_pkg::ST_NO_BLOCK;
						else r.rd = byte_store[b*bs + pos%bs];
					end
				end
				default: ;
			endcase
			r.size = fba_pkg::SIZE_W'(node_bytes[nd]);
			r.mode = node_attr[nd];
		end
		return r;
	endfunction

	// items are taken strictly in order, so predicting at queue time matches acceptance
	task automatic push_item(logic [fba_pkg::OP_W-1:0] op, int nd, logic [15:0] attrs,
			int pos, logic [7:0] wb);
		pending_items.push_back({3'b0, wb, pos[11:0], attrs, nd[5:0], op});
		expected_results.push_back(apply_op(op, nd, attrs, pos, wb));
	endtask

	task automatic push_random_item();
		int used_list [$];
		int pick, nd, pos, lim;
		logic [fba_pkg::OP_W-1:0] op;
		for (int i = 0; i < NODES; i++)
			if (node_used[i] && i < eff_nodes()) used_list.push_back(i);
		pick = $urandom_range(0, 99);
		if (pick < 14) op = fba_pkg::OP_RESERVE;
		else if (pick < 21) op = fba_pkg::OP_RELEASE;
		else if (pick < 35) op = fba_pkg::OP_SET;
		else if (pick < 68) op = fba_pkg::OP_WRITE;
		else if (pick < 88) op = fba_pkg::OP_READ;
		else if (pick < 96) op = fba_pkg::OP_QUERY;
		else op = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
		if (used_list.size() > 0 && $urandom_range(0, 9) < 8)
			nd = used_list[$urandom_range(0, used_list.size()-1)];
		else
			nd = $urandom_range(0, NODES-1);
		lim = eff_bsize() * LINKS;
		pick = $urandom_range(0, 9);
		if (pick == 0) pos = $urandom_range(0, 4095);
		else if (op == fba_pkg::OP_SET) pos = $urandom_range(0, lim + 2);
		else if (op == fba_pkg::OP_WRITE && pick < 7) pos = node_bytes[nd];
		else pos = (node_bytes[nd] > 0) ? $urandom_range(0, node_bytes[nd]) : 0;
		push_item(op, nd, 16'($urandom_range(0, 16'hFFFF)), pos, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || expected_results.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(int bsz, int bcnt, int ncnt);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= fba_pkg::CFG_BLOCK_SIZE;
		cfg_data <= fba_pkg::CFG_D_W'(bsz);
		@(posedge clk);
		cfg_index <= fba_pkg::CFG_BLOCK_COUNT;
		cfg_data <= fba_pkg::CFG_D_W'(bcnt);
		@(posedge clk);
		cfg_index <= fba_pkg::CFG_NODE_COUNT;
		cfg_data <= fba_pkg::CFG_D_W'(ncnt);
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_bsize = bsz[8:0];
		reg_bcount = bcnt[10:0];
		reg_ncount = ncnt[6:0];
	endtask

	task automatic run_random(int n);
		repeat (n) push_random_item();
		wait_idle();
	endtask

	// sender: bursts of random length separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				s_tdata <= pending_items.pop_front();
				s_tvalid <= 1'b1;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 16);
					gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
				end else
					burst_left <= burst_left - 1;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// receiver: stall pattern of its own plus long hold-offs that back up the input
	int hold_left = 0;
	int stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && (result_count == 60 || result_count == 320))
				hold_left <= 600;
			else if (hold_left > 0)
				hold_left <= hold_left - 1;
			if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
			if (hold_left > 0) m_tready <= 1'b0;
			else case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// compare each result item against the oldest prediction
	always @(posedge clk) begin
		fs_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[44:0];
			result_count <= result_count + 1;
			if (expected_results.size() == 0) begin
				$error("result item with no prediction pending: %h", m_tdata);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.status != want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					fail_count++;
				end
				if (got.node != want.node) begin
					$error("node_out: expected %0d, got %0d", want.node, got.node);
					fail_count++;
				end
				if (got.rd != want.rd) begin
					$error("read_byte: expected %0d, got %0d", want.rd, got.rd);
					fail_count++;
				end
				if (got.size != want.size) begin
					$error("file_size: expected %0d, got %0d", want.size, got.size);
					fail_count++;
				end
				if (got.mode != want.mode) begin
					$error("node_mode: expected %0d, got %0d", want.mode, got.mode);
					fail_count++;
				end
			end
		end
	end

	// watchdog: covers the store sweep after reset
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NODES; i++) begin
			node_used[i] = 1'b0;
			node_attr[i] = '0;
			node_bytes[i] = 0;
		end
		for (int i = 0; i < NODES*LINKS; i++) link_tab[i] = NO_BLK;
		for (int i = 0; i < BLOCKS; i++) blk_used[i] = 1'b0;
		for (int i = 0; i < BLOCKS*BYTES; i++) byte_store[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, directed corners
		write_regs(256, 1024, 64);
		push_item(fba_pkg::OP_QUERY, 0, 0, 0, 0);
		push_item(fba_pkg::OP_RESERVE, 0, 16'hFFFF, 0, 0);
		push_item(fba_pkg::OP_RESERVE, 0, 16'h0000, 4095, 8'hFF);
		push_item(fba_pkg::OP_SET, 0, 0, 2048, 0);
		push_item(fba_pkg::OP_SET, 0, 0, 2049, 0);
		push_item(fba_pkg::OP_WRITE, 0, 0, 0, 8'hFF);
		push_item(fba_pkg::OP_READ, 0, 0, 0, 0);
		push_item(fba_pkg::OP_WRITE, 0, 0, 2047, 8'h5A);
		push_item(fba_pkg::OP_READ, 0, 0, 2047, 0);
		push_item(fba_pkg::OP_READ, 0, 0, 2048, 0);
		push_item(fba_pkg::OP_WRITE, 0, 0, 2048, 8'h11);
		push_item(fba_pkg::OP_WRITE, 1, 0, 4095, 8'h22);
		push_item(fba_pkg::OP_WRITE, 1, 0, 0, 8'hA5);
		push_item(fba_pkg::OP_SET, 1, 0, 300, 0);
		push_item(fba_pkg::OP_READ, 1, 0, 299, 0);
		push_item(fba_pkg::OP_SET, 1, 0, 10, 0);
		push_item(fba_pkg::OP_WRITE, 1, 0, 10, 8'h33);
		push_item(OP_UNUSED_A, 1, 0, 0, 0);
		push_item(OP_UNUSED_B, 63, 16'hFFFF, 4095, 8'hFF);
		push_item(fba_pkg::OP_RELEASE, 1, 0, 0, 0);
		push_item(fba_pkg::OP_QUERY, 1, 0, 0, 0);
		push_item(fba_pkg::OP_READ, 63, 0, 0, 0);
		wait_idle();

		// tiny blocks, few of them: no free node, blocks exhausted, failed growth
		write_regs(1, 12, 4);
		repeat (5) push_item(fba_pkg::OP_RESERVE, 0, 16'($urandom_range(0, 16'hFFFF)), 0, 0);
		push_item(fba_pkg::OP_SET, 1, 0, 8, 0);
		push_item(fba_pkg::OP_SET, 2, 0, 8, 0);
		push_item(fba_pkg::OP_WRITE, 3, 0, 0, 8'h77);
		push_item(fba_pkg::OP_WRITE, 2, 0, 7, 8'h44);
		push_item(fba_pkg::OP_READ, 0, 0, 100, 0);
		push_item(fba_pkg::OP_QUERY, 4, 0, 0, 0);
		run_random(100);

		write_regs(16, 64, 16);
		run_random(150);

		// lowered block size leaves sizes beyond the link range
		write_regs(3, 1024, 64);
		push_item(fba_pkg::OP_READ, 0, 0, 100, 0);
		run_random(150);

		write_regs(0, 2047, 127);
		run_random(40);
		write_regs(511, 1024, 64);
		run_random(100);

		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
